// ===== rtl/mmc_pkg.sv =====
// Shared types and constants for the magnetometer min/max calibrator.
// Used by the top level; no dependencies.
`default_nettype none

package mmc_pkg;

  // Input opcodes; the spare code is handled as a limits report
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  typedef enum logic [2:0] {
    KIND_MEASURE  = 3'd0,
    KIND_ABSORBED = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_REPORT   = 3'd3,
    KIND_STARTED  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_HALF,
    ST_GAIN_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  localparam logic [15:0] CAL_LEN_RESET = 16'd100;
  localparam int HALF_DIVISOR = 15;

  // Preset limits, wrapped to the sample width where they are used
  localparam int PRESET_LOW_X  = 8207;
  localparam int PRESET_LOW_Y  = -11261;
  localparam int PRESET_LOW_Z  = -38309;
  localparam int PRESET_HIGH_X = 40073;
  localparam int PRESET_HIGH_Y = 19496;
  localparam int PRESET_HIGH_Z = -700;

endpackage

`default_nettype wire

// ===== rtl/mmc_multiplier.sv =====
// Digit-serial unsigned multiplier: eight multiplier bits per cycle, MSB first.
// Stand-alone; shared across the three axes by the calibrator sequencer.
`default_nettype none

module mmc_multiplier #(
  parameter int SB = 18,
  parameter int GB = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [SB-1:0]                        mag,
  input  logic [GB-1:0]                        gain,
  output logic [SB+8*((GB+7)/8)-1:0]           product,
  output logic                                 done
);

  localparam int DIGIT_BITS = 8;
  localparam int NDIG = (GB + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PADW = DIGIT_BITS * NDIG;
  localparam int PW = SB + PADW;
  localparam int CW = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [SB-1:0]            mag_r;
  logic [PADW-1:0]          digits;
  logic [PW-1:0]            acc;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic [SB+DIGIT_BITS-1:0] step_prod;
  logic [PW-1:0]            acc_next;

  assign step_prod = (SB+DIGIT_BITS)'(mag_r) *
                     (SB+DIGIT_BITS)'(digits[PADW-1 -: DIGIT_BITS]);
  assign acc_next  = {acc[PW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}} + PW'(step_prod);
  assign product   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NDIG - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= mag;
      digits <= PADW'(gain);
      acc    <= '0;
    end else if (busy) begin
      acc    <= acc_next;
      digits <= {digits[PADW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the gain recompute.
// Stand-alone; the caller guarantees the initial remainder is below the divisor.
`default_nettype none

module mmc_divider #(
  parameter int DW = 21,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] bits,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [QW-1:0] bits_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          fits;

  assign shifted = {rem, bits_r[QW-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= rem_init;
      den_r  <= den;
      bits_r <= bits;
      quot   <= '0;
    end else if (busy) begin
      rem    <= fits ? trial[DW-1:0] : shifted[DW-1:0];
      bits_r <= {bits_r[QW-2:0], 1'b0};
      quot   <= {quot[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/magnetometer_min_max_calibrator_unit.sv =====
// Top level of the magnetometer min/max calibrator: sequencer, state and output beat.
// Depends on mmc_pkg, mmc_multiplier and mmc_divider.
`default_nettype none

// One item at a time: in_stall is low only while the sequencer idles, and a
// finished result waits in the output register so the next beat may enter.
// A measurement runs the digit-serial multiplier, which serves all three axes,
// once per axis in turn, and the sample that ends calibration recomputes the
// offsets and gains axis by axis with the bit-serial gain divider.
// After reset the same recompute runs from the preset limits with in_stall
// high; configuration writes are taken meanwhile.

module magnetometer_min_max_calibrator_unit #(
  parameter int SAMPLE_BITS    = 18,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic signed [SAMPLE_BITS-1:0] raw_x,
  input  logic signed [SAMPLE_BITS-1:0] raw_y,
  input  logic signed [SAMPLE_BITS-1:0] raw_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mmc_pkg::kind_t                result_kind,
  output logic signed [SAMPLE_BITS-1:0] corrected_x,
  output logic signed [SAMPLE_BITS-1:0] corrected_y,
  output logic signed [SAMPLE_BITS-1:0] corrected_z,
  output logic signed [SAMPLE_BITS-1:0] low_x,
  output logic signed [SAMPLE_BITS-1:0] high_x,
  output logic signed [SAMPLE_BITS-1:0] low_y,
  output logic signed [SAMPLE_BITS-1:0] high_y,
  output logic signed [SAMPLE_BITS-1:0] low_z,
  output logic signed [SAMPLE_BITS-1:0] high_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data
);

  import mmc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int GF   = GAIN_FRAC_BITS;
  localparam int GB   = GF + 8;
  localparam int DW   = SB + 3;
  localparam int PW   = SB + 8 * ((GB + 7) / 8);
  localparam int QW   = PW - GF;

  state_t state, state_next;

  logic [1:0]           axis;
  logic [1:0]           axis_inc;
  logic                 init_pass;
  logic                 calibrating;
  logic [15:0]          counter;
  logic [15:0]          cal_len;
  logic signed [SB-1:0] minimum [3];
  logic signed [SB-1:0] maximum [3];
  logic signed [SB-1:0] offset [3];
  logic [GB-1:0]        gain [3];
  logic signed [SB-1:0] half_len [3];
  logic signed [SB+1:0] sum;
  logic signed [SB-1:0] raw_r [3];
  logic signed [SB-1:0] cor [3];
  logic                 neg_r;
  kind_t                kind_r;

  logic signed [SB-1:0] raw_in [3];
  logic                 accept;
  logic                 mul_start;
  logic                 div_start;
  logic                 emit_load;
  logic                 gain_ok;
  logic                 gain_ovf;
  logic                 last_axis;

  // measurement datapath
  logic signed [SB:0]   diff;
  logic [SB:0]          diff_abs;
  logic [PW-1:0]        mul_product;
  logic                 mul_done;
  logic [QW-1:0]        prod;
  logic                 pos_ovf;
  logic                 neg_ovf;
  logic signed [SB-1:0] cor_val;

  // recompute datapath
  logic signed [SB:0]   lim_sum;
  logic signed [SB:0]   lim_dif;
  logic signed [SB:0]   sum_adj;
  logic signed [SB:0]   dif_adj;
  logic signed [SB-1:0] off_val;
  logic signed [SB-1:0] half_val;
  logic signed [SB+1:0] half_ext;
  logic signed [SB-1:0] half_cur;
  logic [DW-1:0]        den;
  logic [DW-1:0]        sum_hi;
  logic [GB-1:0]        div_bits;
  logic [GB-1:0]        div_quot;
  logic                 div_done;

  assign raw_in[0] = raw_x;
  assign raw_in[1] = raw_y;
  assign raw_in[2] = raw_z;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign last_axis = (axis == 2'd2);
  assign axis_inc  = last_axis ? 2'd0 : axis + 2'd1;

  // |raw - offset| stays below 2^SB, so the magnitude fits SB bits
  assign diff     = {raw_r[axis][SB-1], raw_r[axis]} - {offset[axis][SB-1], offset[axis]};
  assign diff_abs = diff[SB] ? -diff : diff;

  // drop the fraction bits, then saturate to the sample range
  assign prod    = mul_product[PW-1:GF];
  assign pos_ovf = |prod[QW-1:SB-1];
  assign neg_ovf = (|prod[QW-1:SB]) || (prod[SB-1] && (|prod[SB-2:0]));

  always_comb begin
    if (neg_r) begin
      cor_val = neg_ovf ? {1'b1, {(SB-1){1'b0}}} : (~prod[SB-1:0] + 1'b1);
    end else begin
      cor_val = pos_ovf ? {1'b0, {(SB-1){1'b1}}} : prod[SB-1:0];
    end
  end

  // halve toward zero: add one to a negative value before the shift
  assign lim_sum  = {maximum[axis][SB-1], maximum[axis]} + {minimum[axis][SB-1], minimum[axis]};
  assign lim_dif  = {maximum[axis][SB-1], maximum[axis]} - {minimum[axis][SB-1], minimum[axis]};
  assign sum_adj  = lim_sum + {{SB{1'b0}}, lim_sum[SB]};
  assign dif_adj  = lim_dif + {{SB{1'b0}}, lim_dif[SB]};
  assign off_val  = sum_adj[SB:1];
  assign half_val = dif_adj[SB:1];
  assign half_ext = {{2{half_val[SB-1]}}, half_val};

  // gain = (sum << GF) / (15 * half); the quotient overflows GB bits
  // exactly when sum / 256 reaches the divisor
  assign half_cur = half_len[axis];
  assign den      = DW'(half_cur[SB-2:0]) * DW'(HALF_DIVISOR);
  assign sum_hi   = DW'(sum[SB+1:8]);
  assign div_bits = {sum[7:0], {GF{1'b0}}};
  assign gain_ok  = (half_cur > 0) && (sum > 0);
  assign gain_ovf = sum_hi >= den;

  mmc_multiplier #(
    .SB (SB),
    .GB (GB)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mag     (diff_abs[SB-1:0]),
    .gain    (gain[axis]),
    .product (mul_product),
    .done    (mul_done)
  );

  mmc_divider #(
    .DW (DW),
    .QW (GB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (sum_hi),
    .bits     (div_bits),
    .den      (den),
    .quot     (div_quot),
    .done     (div_done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (opcode)
            OP_SAMPLE: begin
              if (!calibrating) begin
                state_next = ST_MUL_START;
              end else if (counter > cal_len) begin
                state_next = ST_HALF;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: state_next = ST_EMIT;
          endcase
        end
      end
      ST_MUL_START: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = last_axis ? ST_EMIT : ST_MUL_START;
        end
      end
      ST_HALF: begin
        if (last_axis) begin
          state_next = ST_GAIN_START;
        end
      end
      ST_GAIN_START: begin
        if (gain_ok && !gain_ovf) begin
          state_next = ST_DIV_WAIT;
        end else if (last_axis) begin
          state_next = init_pass ? ST_IDLE : ST_EMIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (last_axis) begin
            state_next = init_pass ? ST_IDLE : ST_EMIT;
          end else begin
            state_next = ST_GAIN_START;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mul_start = (state == ST_MUL_START);
    div_start = (state == ST_GAIN_START) && gain_ok && !gain_ovf;
    emit_load = (state == ST_EMIT) && (!out_valid || !out_stall);
  end

  // control state and limits
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HALF;
      axis        <= 2'd0;
      init_pass   <= 1'b1;
      calibrating <= 1'b0;
      counter     <= '0;
      cal_len     <= CAL_LEN_RESET;
      out_valid   <= 1'b0;
      minimum[0]  <= SB'(PRESET_LOW_X);
      minimum[1]  <= SB'(PRESET_LOW_Y);
      minimum[2]  <= SB'(PRESET_LOW_Z);
      maximum[0]  <= SB'(PRESET_HIGH_X);
      maximum[1]  <= SB'(PRESET_HIGH_Y);
      maximum[2]  <= SB'(PRESET_HIGH_Z);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        cal_len <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          init_pass <= 1'b0;
          if (accept) begin
            axis <= 2'd0;
            priority case (opcode)
              OP_SAMPLE: begin
                if (calibrating) begin
                  for (int i = 0; i < 3; i++) begin
                    if (raw_in[i] > maximum[i]) begin
                      maximum[i] <= raw_in[i];
                    end
                    if (raw_in[i] < minimum[i]) begin
                      minimum[i] <= raw_in[i];
                    end
                  end
                  counter <= counter + 16'd1;
                  if (counter > cal_len) begin
                    calibrating <= 1'b0;
                  end
                end
              end
              OP_START: begin
                calibrating <= 1'b1;
                counter     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            axis <= axis_inc;
          end
        end
        ST_HALF: axis <= axis_inc;
        ST_GAIN_START: begin
          if (!(gain_ok && !gain_ovf)) begin
            axis <= axis_inc;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            axis <= axis_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload: working values, derived calibration and the output beat
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            raw_r[i] <= raw_in[i];
            cor[i]   <= '0;
          end
          priority case (opcode)
            OP_SAMPLE: begin
              if (!calibrating) begin
                kind_r <= KIND_MEASURE;
              end else if (counter > cal_len) begin
                kind_r <= KIND_DONE;
              end else begin
                kind_r <= KIND_ABSORBED;
              end
            end
            OP_START: kind_r <= KIND_STARTED;
            default:  kind_r <= KIND_REPORT;
          endcase
        end
      end
      ST_MUL_START: neg_r <= diff[SB];
      ST_MUL_WAIT: begin
        if (mul_done) begin
          cor[axis] <= cor_val;
        end
      end
      ST_HALF: begin
        offset[axis]   <= off_val;
        half_len[axis] <= half_val;
        sum            <= ((axis == 2'd0) ? '0 : sum) + half_ext;
      end
      ST_GAIN_START: begin
        if (!gain_ok) begin
          gain[axis] <= '0;
        end else if (gain_ovf) begin
          gain[axis] <= '1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          gain[axis] <= div_quot;
        end
      end
      default: begin
      end
    endcase

    if (emit_load) begin
      result_kind <= kind_r;
      corrected_x <= cor[0];
      corrected_y <= cor[1];
      corrected_z <= cor[2];
      low_x       <= minimum[0];
      high_x      <= maximum[0];
      low_y       <= minimum[1];
      high_y      <= maximum[1];
      low_z       <= minimum[2];
      high_z      <= maximum[2];
    end
  end

endmodule

`default_nettype wire
